// ----- hdl/bcwg_pkg.sv -----
package bcwg_pkg;

    localparam int WORD_W       = 64;
    localparam int HALF_W       = WORD_W / 2;
    localparam int PROB_BITS_DEF = 8;
    localparam int FORCE_W      = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int GEN_WORDS    = 4;
    localparam int GEN_IDX_W    = 2;

    // SplitMix64 constants
    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

    // opcodes of the op field
    localparam logic OP_RESEED   = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // force_mode codes
    localparam logic [FORCE_W-1:0] FORCE_NORMAL = 2'd0;
    localparam logic [FORCE_W-1:0] FORCE_ZEROS  = 2'd1;
    localparam logic [FORCE_W-1:0] FORCE_ONES   = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PROB_CODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORCE_MODE = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM_ADD,
        ST_SM_MIX1,
        ST_SM_MUL1,
        ST_SM_MIX2,
        ST_SM_MUL2,
        ST_SM_STORE,
        ST_DRAW,
        ST_FOLD,
        ST_OUT_LO,
        ST_OUT_HI
    } seq_state_t;

    typedef struct packed {
        logic                 load;
        logic [GEN_IDX_W-1:0] load_idx;
        logic                 step;
    } xo_ctrl_t;

    typedef struct packed {
        logic clear;
        logic force_en;
        logic force_ones;
    } acc_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v,
                                                  input int unsigned n);
        rotl64 = (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

// ----- hdl/bcwg_mul_unit.sv -----
// 64x64 multiply, low 64 bits of the product, over three 32x32 partial products.
module bcwg_mul_unit
    import bcwg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] prod
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;

    logic [WORD_W-1:0] a_reg, b_reg, acc_reg, acc_next;
    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [HALF_W-1:0] mx_a, mx_b;
    logic [WORD_W-1:0] pp;

    always_comb
    begin
        case (step_reg)
            STEP_LL:
            begin
                mx_a = a_reg[HALF_W-1:0];
                mx_b = b_reg[HALF_W-1:0];
            end
            STEP_LH:
            begin
                mx_a = a_reg[HALF_W-1:0];
                mx_b = b_reg[WORD_W-1:HALF_W];
            end
            default:
            begin
                mx_a = a_reg[WORD_W-1:HALF_W];
                mx_b = b_reg[HALF_W-1:0];
            end
        endcase
    end

    assign pp = WORD_W'(mx_a) * WORD_W'(mx_b);

    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_LL;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LL)
                acc_next = pp;
            else
                acc_next = acc_reg + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
            step_next = step_reg + 2'd1;
            if (step_reg == STEP_HL)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_LL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hdl/bcwg_xoshiro_unit.sv -----
// xoshiro256** state words and one-draw-per-cycle update.
// The *5 is registered with the draw; the rotate and *9 are combinational on that register.
module bcwg_xoshiro_unit
    import bcwg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  xo_ctrl_t          ctrl,
    input  logic [WORD_W-1:0] load_data,
    output logic              y_valid,
    output logic [WORD_W-1:0] y
);

    logic [WORD_W-1:0] s_reg [GEN_WORDS];
    logic [WORD_W-1:0] s_next [GEN_WORDS];
    logic [WORD_W-1:0] t2, t3;
    logic [WORD_W-1:0] mul5_reg;
    logic [WORD_W-1:0] rot;
    logic              y_valid_reg;

    always_comb
    begin
        t2 = s_reg[2] ^ s_reg[0];
        t3 = s_reg[3] ^ s_reg[1];
        for (int i = 0; i < GEN_WORDS; i++)
            s_next[i] = s_reg[i];
        if (ctrl.load)
        begin
            s_next[ctrl.load_idx] = load_data;
        end
        else if (ctrl.step)
        begin
            s_next[0] = s_reg[0] ^ t3;
            s_next[1] = s_reg[1] ^ t2;
            s_next[2] = t2 ^ (s_reg[1] << 17);
            s_next[3] = rotl64(t3, 45);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GEN_WORDS; i++)
                s_reg[i] <= '0;
            y_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < GEN_WORDS; i++)
                s_reg[i] <= s_next[i];
            y_valid_reg <= ctrl.step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
            mul5_reg <= s_reg[1] + (s_reg[1] << 2);
    end

    assign rot     = rotl64(mul5_reg, 7);
    assign y       = rot + (rot << 3);
    assign y_valid = y_valid_reg;

endmodule

// ----- hdl/bcwg_coin_accum.sv -----
// Bit-slice fold: tracks the all-ones prefix per column and sets bits whose
// first zero lands on a level with a 1 in the probability code.
module bcwg_coin_accum
    import bcwg_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  acc_ctrl_t            ctrl,
    input  logic [PROB_BITS-1:0] prob_code,
    input  logic                 y_valid,
    input  logic [WORD_W-1:0]    y,
    output logic [WORD_W-1:0]    lo,
    output logic [WORD_W-1:0]    hi
);

    logic [WORD_W-1:0]    pre_lo_reg, pre_hi_reg, lo_reg, hi_reg;
    logic [PROB_BITS-1:0] prob_sh_reg;
    logic                 half_reg;
    logic [WORD_W-1:0]    pre_sel, first_zero;
    logic                 level_on;

    assign pre_sel    = half_reg ? pre_hi_reg : pre_lo_reg;
    assign first_zero = pre_sel & ~y;
    assign level_on   = prob_sh_reg[PROB_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_reg <= 1'b0;
        else if (ctrl.clear)
            half_reg <= 1'b0;
        else if (y_valid)
            half_reg <= ~half_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.force_en)
        begin
            lo_reg <= {WORD_W{ctrl.force_ones}};
            hi_reg <= {WORD_W{ctrl.force_ones}};
        end
        else if (ctrl.clear)
        begin
            pre_lo_reg  <= '1;
            pre_hi_reg  <= '1;
            lo_reg      <= '0;
            hi_reg      <= '0;
            prob_sh_reg <= prob_code;
        end
        else if (y_valid)
        begin
            if (!half_reg)
            begin
                pre_lo_reg <= pre_lo_reg & y;
                if (level_on)
                    lo_reg <= lo_reg | first_zero;
            end
            else
            begin
                pre_hi_reg <= pre_hi_reg & y;
                if (level_on)
                    hi_reg <= hi_reg | first_zero;
                prob_sh_reg <= prob_sh_reg << 1;
            end
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ----- hdl/bernoulli_coin_word_generator_core.sv -----
// Bernoulli coin word generator on a xoshiro256** source. A reseed beat
// (op = 0) expands seed into the four generator words with the SplitMix64
// mix steps and returns nothing; it holds the block while each word runs its
// two 64x64 multiplies as three 32x32 partial products on one shared
// multiplier. A generate beat (op = 1) returns two output beats, the low 64
// coin bits first and then the high 64 bits with last_half set. In normal
// mode it takes 2*PROB_BITS draws, one per cycle through the generator
// update, then a fold state takes in the last draw, and the two output beats
// follow. Each coin is 1 with probability prob_code / 2^PROB_BITS.
// force_mode 1 or 2 returns all zeros or all ones with no draws and leaves
// the generator alone; code 3 behaves as normal.
// in_stall stays high from acceptance until the second output beat leaves.
// Generating before any reseed uses the all-zero generator state, which
// yields all-zero draws. Configuration writes are always taken (cfg_ready is
// tied high); prob_code keeps its low PROB_BITS bits, and indexes beyond the
// two registers are dropped.
module bernoulli_coin_word_generator_core
    import bcwg_pkg::*;
#(
    parameter int PROB_BITS = PROB_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [((PROB_BITS > FORCE_W) ? PROB_BITS : FORCE_W)-1:0] cfg_wdata,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [WORD_W-1:0]      seed,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [WORD_W-1:0]      coin_bits,
    output logic                   last_half
);

    localparam int DRAWS  = 2 * PROB_BITS;
    localparam int DCNT_W = $clog2(DRAWS);
    localparam logic [DCNT_W-1:0] LAST_DRAW = DCNT_W'(DRAWS - 1);
    localparam logic [GEN_IDX_W-1:0] LAST_WORD = GEN_IDX_W'(GEN_WORDS - 1);

    // configuration registers
    logic [PROB_BITS-1:0] prob_code_reg;
    logic [FORCE_W-1:0]   force_mode_reg;

    // sequencer
    seq_state_t           state_reg, state_next;
    logic [DCNT_W-1:0]    draw_cnt_reg, draw_cnt_next;
    logic [GEN_IDX_W-1:0] word_idx_reg, word_idx_next;
    logic [WORD_W-1:0]    z_reg, z_next;

    logic                 in_take;
    logic                 forced;

    // shared multiplier
    logic                 mul_start;
    logic [WORD_W-1:0]    mul_a, mul_b;
    logic                 mul_done;
    logic [WORD_W-1:0]    mul_prod;

    xo_ctrl_t             xo_ctrl;
    acc_ctrl_t            acc_ctrl;
    logic                 y_valid;
    logic [WORD_W-1:0]    y;
    logic [WORD_W-1:0]    word_lo, word_hi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_code_reg  <= '0;
            force_mode_reg <= FORCE_NORMAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROB_CODE:  prob_code_reg  <= cfg_wdata[PROB_BITS-1:0];
                REG_FORCE_MODE: force_mode_reg <= cfg_wdata[FORCE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign forced   = (force_mode_reg == FORCE_ZEROS) || (force_mode_reg == FORCE_ONES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (op == OP_RESEED)
                        state_next = ST_SM_ADD;
                    else if (forced)
                        state_next = ST_OUT_LO;
                    else
                        state_next = ST_DRAW;
                end
            end
            ST_SM_ADD:   state_next = ST_SM_MIX1;
            ST_SM_MIX1:  state_next = ST_SM_MUL1;
            ST_SM_MUL1:  if (mul_done) state_next = ST_SM_MIX2;
            ST_SM_MIX2:  state_next = ST_SM_MUL2;
            ST_SM_MUL2:  if (mul_done) state_next = ST_SM_STORE;
            ST_SM_STORE: state_next = (word_idx_reg == LAST_WORD) ? ST_IDLE : ST_SM_ADD;
            ST_DRAW:     if (draw_cnt_reg == LAST_DRAW) state_next = ST_FOLD;
            ST_FOLD:     state_next = ST_OUT_LO;
            ST_OUT_LO:   if (!out_stall) state_next = ST_OUT_HI;
            ST_OUT_HI:   if (!out_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        draw_cnt_next       = draw_cnt_reg;
        word_idx_next       = word_idx_reg;
        z_next              = z_reg;
        mul_start           = 1'b0;
        mul_a               = z_reg ^ (z_reg >> 30);
        mul_b               = SM_MUL1;
        xo_ctrl.load        = 1'b0;
        xo_ctrl.load_idx    = word_idx_reg;
        xo_ctrl.step        = 1'b0;
        acc_ctrl.clear      = 1'b0;
        acc_ctrl.force_en   = 1'b0;
        acc_ctrl.force_ones = (force_mode_reg == FORCE_ONES);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (op == OP_RESEED)
                    begin
                        z_next        = seed;
                        word_idx_next = '0;
                    end
                    else if (forced)
                    begin
                        acc_ctrl.force_en = 1'b1;
                    end
                    else
                    begin
                        acc_ctrl.clear = 1'b1;
                        draw_cnt_next  = '0;
                    end
                end
            end
            ST_SM_ADD:
            begin
                z_next = z_reg + SM_GAMMA;
            end
            ST_SM_MIX1:
            begin
                mul_start = 1'b1;
            end
            ST_SM_MIX2:
            begin
                mul_start = 1'b1;
                mul_a     = mul_prod ^ (mul_prod >> 27);
                mul_b     = SM_MUL2;
            end
            ST_SM_STORE:
            begin
                // the mixed value carries on as the SplitMix state
                z_next        = mul_prod;
                xo_ctrl.load  = 1'b1;
                word_idx_next = word_idx_reg + GEN_IDX_W'(1);
            end
            ST_DRAW:
            begin
                xo_ctrl.step  = 1'b1;
                draw_cnt_next = draw_cnt_reg + DCNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            draw_cnt_reg <= '0;
            word_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            draw_cnt_reg <= draw_cnt_next;
            word_idx_reg <= word_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg <= z_next;
    end

    bcwg_mul_unit u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    bcwg_xoshiro_unit u_xo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (xo_ctrl),
        .load_data (mul_prod ^ (mul_prod >> 31)),
        .y_valid   (y_valid),
        .y         (y)
    );

    bcwg_coin_accum #(
        .PROB_BITS (PROB_BITS)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (acc_ctrl),
        .prob_code (prob_code_reg),
        .y_valid   (y_valid),
        .y         (y),
        .lo        (word_lo),
        .hi        (word_hi)
    );

    // both halves sit in the accumulator registers until the second beat leaves
    assign out_valid = (state_reg == ST_OUT_LO) || (state_reg == ST_OUT_HI);
    assign last_half = (state_reg == ST_OUT_HI);
    assign coin_bits = last_half ? word_hi : word_lo;

endmodule
